// File: design/vref_pkg.sv
// vref_pkg: shared types and constants for the vector refraction block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package vref_pkg;

  // APB register map (byte addresses, decoded on paddr[2])
  localparam int unsigned AddrW = 3;
  localparam logic RegIndexBefore = 1'b0;
  localparam logic RegIndexAfter  = 1'b1;
  localparam logic [15:0] IndexReset = 16'd16384;

  localparam logic [17:0] NrMax    = 18'h3FFFF;
  localparam logic [17:0] CosOne   = 18'd16384;
  localparam logic [28:0] OneQ28   = 29'h1000_0000;
  localparam logic [63:0] OneQ56   = 64'h0100_0000_0000_0000;
  localparam int unsigned DivSteps  = 18;
  localparam int unsigned SqrtSteps = 29;

  // stage map of the pipeline line
  localparam int unsigned StProd  = 1;
  localparam int unsigned StCos   = 2;
  localparam int unsigned StC1    = 3;
  localparam int unsigned StNr    = DivSteps + 1;          // 19
  localparam int unsigned StPart  = StNr + 1;              // 20
  localparam int unsigned StRad   = StPart + 1;            // 21
  localparam int unsigned StGamma = StRad + SqrtSteps + 1; // 51
  localparam int unsigned StProdB = StGamma + 1;           // 52
  localparam int unsigned StOut   = StProdB + 1;           // 53
  localparam int unsigned NumSt   = StOut + 1;

  // one restoring-division cell: one quotient bit per cell
  typedef struct packed {
    logic [15:0] rem;
    logic [17:0] quo;
    logic [17:0] num;
    logic [15:0] dvs;
    logic        sat;
  } div_t;

  // one square-root cell: one root bit per cell
  typedef struct packed {
    logic [30:0] rem;
    logic [28:0] root;
    logic [57:0] x;
  } sqrt_t;

  // request payload as it travels down the line
  typedef struct packed {
    logic [2:0][15:0] dir;
    logic [2:0][15:0] nrm;
    logic             eq;
    logic [2:0][31:0] prod;
    logic [17:0]      cosi;
    logic [28:0]      c1;
    logic [17:0]      nr;
    logic [35:0]      nr2;
    logic [35:0]      nrcosi;
    logic [46:0]      ph;
    logic [46:0]      pl;
    logic [2:0][34:0] a;
    logic             tir;
    logic [56:0]      rad;
    logic [37:0]      gamma;
    logic [2:0][53:0] b;
    logic [2:0][15:0] res;
  } side_t;

endpackage

// File: design/vector_refraction.sv
// vector_refraction: top level, Snell's-law refraction of one ray per cycle when not stalled.
// Depends on vref_pkg, vref_div_cell, vref_sqrt_cell.
`timescale 1ns / 1ps
// Usage:
//  - Request channel: dir_*_i and normal_*_i with in_valid_i; a request is taken
//    on a rising edge with in_valid_i high and in_stall_o low.
//  - Result channel: out_dir_*_o and total_reflection_o with out_valid_o;
//    taken on an edge with out_valid_o high and out_stall_i low.
//  - APB port holds index_before (0x0) and index_after (0x4), Q2.14.
//    The indices are sampled with each request, so write them only when idle.
//  - Depth: 54 stages; out_valid_o is the valid bit of the last stage.
//  - Throughput: one request per cycle when not stalled. The line is a chain of
//    cells: 18 divider cells form the index ratio, one bit each, and 29
//    square-root cells form the root term, one bit each; each cell hands on whenever the line is not stalled.
//  - Stall: when a result waits with out_valid_o high and out_stall_i high,
//    the whole line freezes and in_stall_o rises; otherwise requests flow.
//  - Reset: clears all valid bits and sets both indices to 1.0.
//  - Total internal reflection or equal indices return the input direction;
//    total_reflection_o flags the former.
module vector_refraction import vref_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  input  logic signed [15:0] dir_z_i,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] out_dir_x_o,
  output logic signed [15:0] out_dir_y_o,
  output logic signed [15:0] out_dir_z_o,
  output logic               total_reflection_o
);

  // config registers
  logic [15:0] idx_before_q, idx_after_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_before_q <= IndexReset;
      idx_after_q  <= IndexReset;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegIndexBefore: idx_before_q <= pwdata[15:0];
        RegIndexAfter:  idx_after_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegIndexBefore: prdata = {16'd0, idx_before_q};
      RegIndexAfter:  prdata = {16'd0, idx_after_q};
      default:        prdata = '0;
    endcase
  end

  // pipeline line: whole line advances unless a finished result is held
  logic  en;
  logic  valid_q [NumSt];
  logic  valid_d [NumSt];
  side_t side_q  [NumSt];
  side_t side_d  [NumSt];

  assign en         = !(valid_q[StOut] && out_stall_i);
  assign in_stall_o = !en;

  // indices captured with the request
  logic [15:0] idx_before_s, idx_after_s;

  always_ff @(posedge clk_i) begin
    if (en) begin
      idx_before_s <= idx_before_q;
      idx_after_s  <= idx_after_q;
    end
  end

  // divider cells: nr = (index_before << 14) / index_after
  div_t div_init;
  div_t div_w [DivSteps];

  always_comb begin
    div_init.dvs = idx_after_s;
    // quotient overflows 18 bits exactly when index_before >= 16 * index_after
    div_init.sat = {4'd0, idx_before_s} >= {idx_after_s, 4'd0};
    div_init.rem = {4'd0, idx_before_s[15:4]};
    div_init.quo = '0;
    div_init.num = {idx_before_s[3:0], 14'd0};
  end

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    vref_div_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .div_i ((j == 0) ? div_init : div_w[(j == 0) ? 0 : j - 1]),
      .div_o (div_w[j])
    );
  end

  // square-root cells: cosr = floor(sqrt(rad))
  sqrt_t sq_init;
  sqrt_t sq_w [SqrtSteps];

  always_comb begin
    sq_init.rem  = '0;
    sq_init.root = '0;
    sq_init.x    = {1'b0, side_q[StRad].rad};
  end

  for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
    vref_sqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .sq_i  ((j == 0) ? sq_init : sq_w[(j == 0) ? 0 : j - 1]),
      .sq_o  (sq_w[j])
    );
  end

  // per-stage arithmetic
  logic signed [33:0] dot;
  logic        [33:0] dot_abs;
  logic        [35:0] cos_sq;
  logic        [17:0] nr_w;
  logic        [64:0] term;
  logic signed [55:0] acc   [3];
  logic signed [55:0] rnd   [3];
  logic signed [27:0] q14   [3];
  logic        [15:0] sat16 [3];

  always_comb begin
    for (int s = 1; s < NumSt; s++) begin
      side_d[s]  = side_q[s-1];
      valid_d[s] = valid_q[s-1];
    end
    side_d[0]         = side_q[0];
    valid_d[0]        = in_valid_i;
    side_d[0].dir[0]  = dir_x_i;
    side_d[0].dir[1]  = dir_y_i;
    side_d[0].dir[2]  = dir_z_i;
    side_d[0].nrm[0]  = normal_x_i;
    side_d[0].nrm[1]  = normal_y_i;
    side_d[0].nrm[2]  = normal_z_i;
    side_d[0].eq      = idx_before_q == idx_after_q;

    for (int i = 0; i < 3; i++) begin
      side_d[StProd].prod[i] = 32'($signed(side_q[StProd-1].dir[i]) *
                                   $signed(side_q[StProd-1].nrm[i]));
    end

    // incidence cosine, rounded Q.28 -> Q.14
    dot = 34'($signed(side_q[StCos-1].prod[0])) + 34'($signed(side_q[StCos-1].prod[1]))
        + 34'($signed(side_q[StCos-1].prod[2]));
    dot_abs = dot[33] ? 34'(-dot) : dot;
    side_d[StCos].cosi = 18'((dot_abs + 34'd8192) >> 14);

    // 1 - min(cosi^2, 1)
    cos_sq = side_q[StC1-1].cosi * side_q[StC1-1].cosi;
    side_d[StC1].c1 = (side_q[StC1-1].cosi > CosOne) ? '0 : 29'(OneQ28 - 29'(cos_sq));

    nr_w = div_w[DivSteps-1].sat ? NrMax : div_w[DivSteps-1].quo;
    side_d[StNr].nr     = nr_w;
    side_d[StNr].nr2    = nr_w * nr_w;
    side_d[StNr].nrcosi = nr_w * side_q[StNr-1].cosi;

    // c1 * nr^2 in two partial products
    side_d[StPart].ph = side_q[StPart-1].c1 * side_q[StPart-1].nr2[35:18];
    side_d[StPart].pl = side_q[StPart-1].c1 * side_q[StPart-1].nr2[17:0];
    for (int i = 0; i < 3; i++) begin
      side_d[StPart].a[i] = 35'($signed({1'b0, side_q[StPart-1].nr}) *
                                $signed(side_q[StPart-1].dir[i]));
    end

    term = {side_q[StRad-1].ph, 18'd0} + 65'(side_q[StRad-1].pl);
    side_d[StRad].tir = term[63:0] > OneQ56;
    side_d[StRad].rad = 57'(OneQ56 - term[63:0]);

    side_d[StGamma].gamma = $signed({2'b00, side_q[StGamma-1].nrcosi}) -
                            $signed({9'd0, sq_w[SqrtSteps-1].root});

    for (int i = 0; i < 3; i++) begin
      side_d[StProdB].b[i] = 54'($signed(side_q[StProdB-1].gamma) *
                                 $signed(side_q[StProdB-1].nrm[i]));
    end

    // Q.42 -> Q.14, round half up, saturate
    for (int i = 0; i < 3; i++) begin
      acc[i] = ($signed(56'($signed(side_q[StOut-1].a[i]))) <<< 14) +
               $signed(56'($signed(side_q[StOut-1].b[i])));
      rnd[i] = acc[i] + 56'sd134217728;
      q14[i] = 28'(rnd[i] >>> 28);
      if (q14[i] > 28'sd32767) begin
        sat16[i] = 16'h7FFF;
      end else if (q14[i] < -28'sd32768) begin
        sat16[i] = 16'h8000;
      end else begin
        sat16[i] = q14[i][15:0];
      end
      side_d[StOut].res[i] = (side_q[StOut-1].eq || side_q[StOut-1].tir) ?
                             side_q[StOut-1].dir[i] : sat16[i];
    end
    side_d[StOut].tir = side_q[StOut-1].tir && !side_q[StOut-1].eq;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NumSt; s++) begin
        valid_q[s] <= 1'b0;
      end
    end else if (en) begin
      for (int s = 0; s < NumSt; s++) begin
        valid_q[s] <= valid_d[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < NumSt; s++) begin
        side_q[s] <= side_d[s];
      end
    end
  end

  assign out_valid_o        = valid_q[StOut];
  assign out_dir_x_o        = side_q[StOut].res[0];
  assign out_dir_y_o        = side_q[StOut].res[1];
  assign out_dir_z_o        = side_q[StOut].res[2];
  assign total_reflection_o = side_q[StOut].tir;

  // checks
  a_flag_not_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && total_reflection_o |-> !side_q[StOut].eq)
    else $error("reflection flag with equal indices");

  a_line_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && valid_q[StOut-1] |=> out_valid_o)
    else $error("request lost at last stage");

  a_stall_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

endmodule

// File: design/vref_div_cell.sv
// vref_div_cell: one step of the index-ratio divider chain.
// Depends on vref_pkg (div_t).
`timescale 1ns / 1ps
module vref_div_cell import vref_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  div_t div_i,
  output div_t div_o
);

  div_t        div_d, div_q;
  logic [16:0] trial;
  logic        ge;

  always_comb begin
    trial = {div_i.rem, div_i.num[17]};
    ge    = trial >= {1'b0, div_i.dvs};
    div_d = div_i;
    div_d.rem = ge ? 16'(trial - {1'b0, div_i.dvs}) : trial[15:0];
    div_d.quo = {div_i.quo[16:0], ge};
    div_d.num = {div_i.num[16:0], 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

// File: design/vref_sqrt_cell.sv
// vref_sqrt_cell: one digit step of the integer square-root chain.
// Depends on vref_pkg (sqrt_t).
`timescale 1ns / 1ps
module vref_sqrt_cell import vref_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  sqrt_t sq_i,
  output sqrt_t sq_o
);

  sqrt_t       sq_d, sq_q;
  logic [32:0] rem2;
  logic [32:0] trial;
  logic        ge;

  always_comb begin
    rem2  = {sq_i.rem, sq_i.x[57:56]};
    trial = {2'b00, sq_i.root, 2'b01};
    ge    = rem2 >= trial;
    sq_d.rem  = ge ? 31'(rem2 - trial) : rem2[30:0];
    sq_d.root = {sq_i.root[27:0], ge};
    sq_d.x    = {sq_i.x[55:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule
